/* design/scp_pkg.sv */
package scp_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int MIN_LENGTH   = 16;
  localparam int CNT_W        = $clog2(MIN_LENGTH + 1);

  localparam logic [7:0]  MAGIC_N   = 8'h4E;
  localparam logic [7:0]  MAGIC_S   = 8'h53;
  localparam logic [15:0] WORD_ONES = 16'hFFFF;
  localparam logic [15:0] SEG_OPEN  = 16'hA5A5;
  localparam logic [15:0] CODE_MARK = 16'hAAAA;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam int TDATA_W = 80;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_CODE   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_MARKER   = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_TOOMANY  = 3'd5,
    ST_ORPHAN   = 3'd6,
    ST_TRAILER  = 3'd7
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] segment_index;
    logic [7:0]  payload;
    status_t     status;
    logic [15:0] heap_size;
    logic [15:0] stack_size;
    logic [15:0] register_count;
    logic        end_of_run;
  } res_t;

  // items handed from the parser to the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    res_t       item0;
    res_t       item1;
  } push_t;

endpackage

/* design/segment_container_parser.sv */
// channel  dir  tdata                            tuser    tlast
// s_       in   [7:0] data_byte                  -        last_byte
// m_       out  segment_index,payload,status,    kind     end_of_run
//               heap_size,stack_size,register_count
//
// one byte item accepted per cycle while s_tready is high; the per-byte decode sits between the
// parser state registers and a four-entry result queue
// a status item is pushed into the result queue in the cycle that the last byte is accepted
// a payload byte is decided, and pushed into the result queue, once the byte
// four places after it is accepted
// the last byte of a file can give two results, payload then status
// s_tready drops only while the result queue has fewer than two free slots
// rst is synchronous; after reset the block waits for the first byte
module segment_container_parser
  import scp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] data_byte
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [15:0] segment_index, [23:16] payload,
                                        // [26:24] status, [42:27] heap_size,
                                        // [58:43] stack_size, [74:59] register_count
  output logic [1:0]         m_tuser,   // [1:0] kind
  output logic               m_tlast
);

  push_t push;
  res_t  head;
  logic  room;
  logic  take;

  assign s_tready = room;
  assign take     = s_tvalid && room;

  scp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .push      (push)
  );

  scp_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (m_tvalid),
    .head_take  (m_tready),
    .head       (head)
  );

  assign m_tdata = {5'd0, head.register_count, head.stack_size, head.heap_size,
                    head.status, head.payload, head.segment_index};
  assign m_tuser = head.kind;
  assign m_tlast = head.end_of_run;

endmodule

/* design/scp_parser.sv */
module scp_parser
  import scp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  logic [CNT_W-1:0] hdr_cnt, hdr_cnt_next;
  logic [7:0]       win [4];
  logic [7:0]       win_next [4];
  logic [15:0]      heap, heap_next;
  logic [15:0]      stack, stack_next;
  logic [15:0]      regs, regs_next;
  logic [15:0]      segs, segs_next;
  logic [16:0]      cur, cur_next;
  logic             code_mode, code_mode_next;
  logic             skip, skip_next;
  logic [15:0]      bsum, bsum_next;
  logic             f_magic, f_magic_next;
  logic             f_marker, f_marker_next;
  logic             f_toomany, f_toomany_next;
  logic             f_orphan, f_orphan_next;

  logic [15:0] hword;
  logic [15:0] pair;
  logic [16:0] cur_inc;
  logic [15:0] csum;
  logic [15:0] trail;
  logic        emit;
  logic        f_short, f_csum, f_trail;
  status_t     status;
  res_t        pay_item, st_item;

  always_comb begin
    hdr_cnt_next   = hdr_cnt;
    win_next       = win;
    heap_next      = heap;
    stack_next     = stack;
    regs_next      = regs;
    segs_next      = segs;
    cur_next       = cur;
    code_mode_next = code_mode;
    skip_next      = skip;
    bsum_next      = bsum;
    f_magic_next   = f_magic;
    f_marker_next  = f_marker;
    f_toomany_next = f_toomany;
    f_orphan_next  = f_orphan;
    emit           = 1'b0;
    hword          = {data_byte, win[3]};
    pair           = {win[1], win[0]};
    cur_inc        = cur + 17'd1;

    // header capture
    if (hdr_cnt < CNT_W'(HEADER_BYTES)) begin
      if (hdr_cnt == CNT_W'(0) && data_byte != MAGIC_N) f_magic_next = 1'b1;
      if (hdr_cnt == CNT_W'(1) && data_byte != MAGIC_S) f_magic_next = 1'b1;
      case (hdr_cnt)
        CNT_W'(3):  if (hword != WORD_ONES) f_marker_next = 1'b1;
        CNT_W'(5):  heap_next  = hword;
        CNT_W'(7):  stack_next = hword;
        CNT_W'(9):  regs_next  = hword;
        CNT_W'(11): segs_next  = hword;
        default: ;
      endcase
    end

    if (hdr_cnt >= CNT_W'(2)) bsum_next = bsum + 16'(win[2]);

    // body byte at the oldest window slot
    if (hdr_cnt >= CNT_W'(MIN_LENGTH) && !f_toomany) begin
      if (skip) begin
        skip_next = 1'b0;
      end else if (pair == SEG_OPEN) begin
        if (cur_inc >= {1'b0, segs}) begin
          f_toomany_next = 1'b1;
        end else begin
          cur_next       = cur_inc;
          code_mode_next = 1'b0;
          skip_next      = 1'b1;
        end
      end else if (pair == CODE_MARK) begin
        if (cur[16]) f_orphan_next = 1'b1;
        code_mode_next = 1'b1;
        skip_next      = 1'b1;
      end else if (cur[16]) begin
        f_orphan_next = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end

    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = win[3];
    win_next[3] = data_byte;
    if (hdr_cnt < CNT_W'(MIN_LENGTH)) hdr_cnt_next = hdr_cnt + CNT_W'(1);

    // end of file checks
    csum    = {data_byte, win[3]};
    trail   = skip_next ? {win[3], win[2]} : {win[2], win[1]};
    f_short = hdr_cnt < CNT_W'(MIN_LENGTH - 1);
    f_csum  = bsum_next != csum;
    f_trail = trail != WORD_ONES;
    if (f_short)             status = ST_SHORT;
    else if (f_magic_next)   status = ST_MAGIC;
    else if (f_marker_next)  status = ST_MARKER;
    else if (f_csum)         status = ST_CHECKSUM;
    else if (f_toomany_next) status = ST_TOOMANY;
    else if (f_orphan_next)  status = ST_ORPHAN;
    else if (f_trail)        status = ST_TRAILER;
    else                     status = ST_OK;

    pay_item.kind           = code_mode ? KIND_CODE : KIND_NAME;
    pay_item.segment_index  = cur[15:0];
    pay_item.payload        = win[0];
    pay_item.status         = ST_OK;
    pay_item.heap_size      = '0;
    pay_item.stack_size     = '0;
    pay_item.register_count = '0;
    pay_item.end_of_run     = 1'b0;

    st_item.kind           = KIND_STATUS;
    st_item.segment_index  = '0;
    st_item.payload        = '0;
    st_item.status         = status;
    st_item.heap_size      = heap_next;
    st_item.stack_size     = stack_next;
    st_item.register_count = regs_next;
    st_item.end_of_run     = 1'b1;

    push.count = 2'd0;
    push.item0 = emit ? pay_item : st_item;
    push.item1 = st_item;
    if (take) push.count = 2'(emit) + 2'(last_byte);

    // back to the idle state for the next file
    if (last_byte) begin
      hdr_cnt_next   = '0;
      for (int i = 0; i < 4; i++) win_next[i] = '0;
      heap_next      = '0;
      stack_next     = '0;
      regs_next      = '0;
      segs_next      = '0;
      cur_next       = '1;
      code_mode_next = 1'b0;
      skip_next      = 1'b0;
      bsum_next      = '0;
      f_magic_next   = 1'b0;
      f_marker_next  = 1'b0;
      f_toomany_next = 1'b0;
      f_orphan_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_cnt   <= '0;
      for (int i = 0; i < 4; i++) win[i] <= '0;
      heap      <= '0;
      stack     <= '0;
      regs      <= '0;
      segs      <= '0;
      cur       <= '1;
      code_mode <= 1'b0;
      skip      <= 1'b0;
      bsum      <= '0;
      f_magic   <= 1'b0;
      f_marker  <= 1'b0;
      f_toomany <= 1'b0;
      f_orphan  <= 1'b0;
    end else if (take) begin
      hdr_cnt   <= hdr_cnt_next;
      win       <= win_next;
      heap      <= heap_next;
      stack     <= stack_next;
      regs      <= regs_next;
      segs      <= segs_next;
      cur       <= cur_next;
      code_mode <= code_mode_next;
      skip      <= skip_next;
      bsum      <= bsum_next;
      f_magic   <= f_magic_next;
      f_marker  <= f_marker_next;
      f_toomany <= f_toomany_next;
      f_orphan  <= f_orphan_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    take && last_byte |=> hdr_cnt == '0 && cur == '1 && !skip && bsum == '0)
    else $error("state not cleared after last item");
  a_two_items: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.item0.kind != KIND_STATUS && push.item1.kind == KIND_STATUS)
    else $error("bad order of two results");
  a_payload_seg: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 && push.item0.kind != KIND_STATUS |-> !cur[16] && !f_toomany)
    else $error("payload emitted without an open segment");
`endif

endmodule

/* design/scp_out_queue.sv */
module scp_out_queue
  import scp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  head_valid,
  input  logic  head_take,
  output res_t  head
);

  res_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr, rd_ptr;
  logic [OQ_CW-1:0] count, count_next;
  logic             pop;

  assign pop        = head_valid && head_take;
  assign head_valid = count != '0;
  assign room       = count <= OQ_CW'(OQ_DEPTH - 2);
  assign head       = mem[rd_ptr];
  assign count_next = count + OQ_CW'(push.count) - OQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.item0;
    if (push.count == 2'd2) mem[wr_ptr + OQ_AW'(1)] <= push.item1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(push.count);
      if (pop) rd_ptr <= rd_ptr + OQ_AW'(1);
      count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CW'(OQ_DEPTH))
    else $error("queue count beyond depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> (count + OQ_CW'(push.count)) <= OQ_CW'(OQ_DEPTH))
    else $error("queue overrun");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && count == OQ_CW'(1) && push.count == 2'd0 |=> !head_valid)
    else $error("queue valid after last item taken");
`endif

endmodule
